@@ src/abvs_pkg.sv @@
// Shared types, constants and the byte-wise CRC-32 step for the A/B boot image selector.
// Used by every module of the selector; depends on nothing else.
`timescale 1ns / 1ps

package abvs_pkg;

  localparam int unsigned MaxImageBytes = 24576;

  localparam int unsigned CountW    = 15;
  localparam int unsigned CrcW      = 32;
  localparam int unsigned AddrW     = 28;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 32;

  localparam logic [CrcW-1:0]  CrcPoly    = 32'hEDB8_8320;
  localparam logic [CrcW-1:0]  CrcInit    = 32'hFFFF_FFFF;
  localparam logic [31:0]      GoodMagic  = 32'h5A5A_5A5A;
  localparam logic [AddrW-1:0] SlotABase  = 28'h800_3000;
  localparam logic [AddrW-1:0] SlotBBase  = 28'h800_9000;
  localparam logic [31:0]      SramLo     = 32'h2000_0000;
  localparam logic [31:0]      SramHi     = 32'h2000_5000;
  localparam logic [31:0]      FlashBase  = 32'h0800_0000;

  localparam logic [1:0] UpgradePending = 2'd2;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_FINISH = 2'd1,
    KIND_VECTOR = 2'd2
  } kind_e;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_STATUS_MAGIC  = 3'd0,
    CFG_ACTIVE_SLOT   = 3'd1,
    CFG_UPGRADE_STATE = 3'd2,
    CFG_EXPECTED_CRC  = 3'd3,
    CFG_IMAGE_SIZE    = 3'd4
  } cfg_index_e;

  typedef struct packed {
    logic cur_slot;
    logic new_slot;
    logic crc_match;
    logic status_rewrite;
  } abvs_decision_t;

  function automatic logic [CrcW-1:0] crc32_byte(logic [CrcW-1:0] crc, logic [7:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {{(CrcW-8){1'b0}}, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [AddrW-1:0] slot_base(logic slot);
    return slot ? SlotBBase : SlotABase;
  endfunction

endpackage

@@ src/abvs_crc.sv @@
// Running CRC-32 and byte count over the inactive slot image.
// Depends on abvs_pkg for the CRC step, the widths and the byte limit.
`timescale 1ns / 1ps

module abvs_crc
  import abvs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              byte_en_i,
  input  logic              clear_i,
  input  logic [7:0]        data_byte_i,
  input  logic [CountW-1:0] image_size_i,
  output logic [CrcW-1:0]   crc_o
);

  logic [CrcW-1:0]   crc_q, crc_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] limit;

  always_comb begin
    limit = image_size_i;
    if (32'(image_size_i) > MaxImageBytes) begin
      limit = CountW'(MaxImageBytes);
    end
    crc_d   = crc_q;
    count_d = count_q;
    if (clear_i) begin
      crc_d   = CrcInit;
      count_d = '0;
    end else if (byte_en_i && (count_q < limit)) begin
      crc_d   = crc32_byte(crc_q, data_byte_i);
      count_d = count_q + CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= CrcInit;
      count_q <= '0;
    end else begin
      crc_q   <= crc_d;
      count_q <= count_d;
    end
  end

  assign crc_o = crc_q;

endmodule

@@ src/abvs_status.sv @@
// Status registers, their write port and the slot decision taken on a finish transaction.
// Depends on abvs_pkg for the register indexes, the magic word and the decision struct.
`timescale 1ns / 1ps

module abvs_status
  import abvs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 finish_en_i,
  input  logic [CrcW-1:0]      computed_crc_i,
  output logic [CountW-1:0]    image_size_o,
  output abvs_decision_t       decision_o
);

  logic [31:0]       magic_q, magic_d;
  logic              slot_q, slot_d;
  logic [1:0]        upgrade_q, upgrade_d;
  logic [CrcW-1:0]   expected_q, expected_d;
  logic [CountW-1:0] size_q, size_d;
  logic              bad_magic;
  logic              pending;
  logic              match;

  assign bad_magic = (magic_q != GoodMagic);
  assign pending   = (upgrade_q == UpgradePending);
  assign match     = (computed_crc_i == expected_q);

  always_comb begin
    decision_o.cur_slot       = slot_q;
    decision_o.crc_match      = match;
    decision_o.status_rewrite = bad_magic || pending;
    if (bad_magic) begin
      decision_o.new_slot = 1'b0;
    end else if (pending) begin
      decision_o.new_slot = slot_q ^ match;
    end else begin
      decision_o.new_slot = slot_q;
    end
  end

  always_comb begin
    magic_d    = magic_q;
    slot_d     = slot_q;
    upgrade_d  = upgrade_q;
    expected_d = expected_q;
    size_d     = size_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_STATUS_MAGIC:  magic_d    = cfg_data_i[31:0];
        CFG_ACTIVE_SLOT:   slot_d     = cfg_data_i[0];
        CFG_UPGRADE_STATE: upgrade_d  = cfg_data_i[1:0];
        CFG_EXPECTED_CRC:  expected_d = cfg_data_i[CrcW-1:0];
        CFG_IMAGE_SIZE:    size_d     = cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end else if (finish_en_i) begin
      if (bad_magic) begin
        magic_d    = GoodMagic;
        slot_d     = 1'b0;
        upgrade_d  = '0;
        expected_d = '0;
        size_d     = '0;
      end else if (pending) begin
        slot_d    = slot_q ^ match;
        upgrade_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q    <= '0;
      slot_q     <= 1'b0;
      upgrade_q  <= '0;
      expected_q <= '0;
      size_q     <= '0;
    end else begin
      magic_q    <= magic_d;
      slot_q     <= slot_d;
      upgrade_q  <= upgrade_d;
      expected_q <= expected_d;
      size_q     <= size_d;
    end
  end

  assign image_size_o = size_q;

endmodule

@@ src/ab_boot_image_verify_select.sv @@
// Top level of the A/B boot image selector: input register, result register and handshakes.
// Depends on abvs_pkg, abvs_crc and abvs_status.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+----------------------------------------------
//   input    | in        | in_valid_i/in_stall_o | kind, data_byte, stack_pointer, reset_vector
//   result   | out       | out_valid_o/out_stall_i | new_slot, boot_address, crc_match,
//            |           |                       | computed_crc, status_rewrite, jump_ok
//   config   | in        | cfg_we_i              | cfg_index_i, cfg_data_i
//
// A transaction is registered in the input register on acceptance and, if it makes a result,
// passes to the result register; one transaction is accepted per cycle while in_stall_o is low.
// The result register decouples the sides: byte transactions keep flowing while a result
// waits, and only a result-producing transaction behind a stalled result holds the input.
// Reset clears the CRC to all ones, the byte count and every status register to zero.
`timescale 1ns / 1ps

module ab_boot_image_verify_select
  import abvs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           kind_i,
  input  logic [7:0]           data_byte_i,
  input  logic [31:0]          stack_pointer_i,
  input  logic [31:0]          reset_vector_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 new_slot_o,
  output logic [AddrW-1:0]     boot_address_o,
  output logic                 crc_match_o,
  output logic [CrcW-1:0]      computed_crc_o,
  output logic                 status_rewrite_o,
  output logic                 jump_ok_o
);

  logic        in_valid_q;
  logic [1:0]  kind_q;
  logic [7:0]  data_byte_q;
  logic [31:0] stack_pointer_q;
  logic [31:0] reset_vector_q;

  logic        out_valid_q;
  logic        new_slot_q;
  logic [AddrW-1:0] boot_address_q;
  logic        crc_match_q;
  logic [CrcW-1:0] computed_crc_q;
  logic        status_rewrite_q;
  logic        jump_ok_q;

  logic        new_slot_d;
  logic        crc_match_d;
  logic [CrcW-1:0] computed_crc_d;
  logic        status_rewrite_d;
  logic        jump_ok_d;

  logic        has_result;
  logic        out_load;
  logic        advance;
  logic        accept;
  logic        is_byte;
  logic        is_finish;
  logic        vector_ok;

  logic [CrcW-1:0]   running_crc;
  logic [CountW-1:0] image_size;
  abvs_decision_t    decision;

  always_comb begin
    is_byte    = 1'b0;
    is_finish  = 1'b0;
    has_result = 1'b0;
    case (kind_q)
      KIND_BYTE:   is_byte = 1'b1;
      KIND_FINISH: begin
        is_finish  = 1'b1;
        has_result = 1'b1;
      end
      KIND_VECTOR: has_result = 1'b1;
      default: ;
    endcase
  end

  assign out_load   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && (!has_result || out_load);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  abvs_crc u_crc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_en_i    (advance && is_byte),
    .clear_i      (advance && is_finish),
    .data_byte_i  (data_byte_q),
    .image_size_i (image_size),
    .crc_o        (running_crc)
  );

  abvs_status u_status (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .finish_en_i    (advance && is_finish),
    .computed_crc_i (~running_crc),
    .image_size_o   (image_size),
    .decision_o     (decision)
  );

  assign vector_ok = (stack_pointer_q >= SramLo) && (stack_pointer_q < SramHi)
                  && (reset_vector_q >= FlashBase);

  always_comb begin
    if (is_finish) begin
      new_slot_d       = decision.new_slot;
      crc_match_d      = decision.crc_match;
      computed_crc_d   = ~running_crc;
      status_rewrite_d = decision.status_rewrite;
      jump_ok_d        = 1'b0;
    end else begin
      new_slot_d       = decision.cur_slot;
      crc_match_d      = 1'b0;
      computed_crc_d   = '0;
      status_rewrite_d = 1'b0;
      jump_ok_d        = vector_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance && has_result) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q          <= kind_i;
      data_byte_q     <= data_byte_i;
      stack_pointer_q <= stack_pointer_i;
      reset_vector_q  <= reset_vector_i;
    end
    if (advance && has_result) begin
      new_slot_q       <= new_slot_d;
      boot_address_q   <= slot_base(new_slot_d);
      crc_match_q      <= crc_match_d;
      computed_crc_q   <= computed_crc_d;
      status_rewrite_q <= status_rewrite_d;
      jump_ok_q        <= jump_ok_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign new_slot_o       = new_slot_q;
  assign boot_address_o   = boot_address_q;
  assign crc_match_o      = crc_match_q;
  assign computed_crc_o   = computed_crc_q;
  assign status_rewrite_o = status_rewrite_q;
  assign jump_ok_o        = jump_ok_q;

endmodule

@@ tb/sv/ab_boot_image_verify_select_tb.sv @@
// Self-checking testbench for the A/B boot image selector: a directed table, then random
// image, finish and vector-check transactions, each result checked against an in-bench model.
// Depends on abvs_pkg and ab_boot_image_verify_select.
`timescale 1ns / 1ps

module ab_boot_image_verify_select_tb;
  import abvs_pkg::*;

  localparam int unsigned ItemTarget   = 1550;
  localparam int unsigned StuckLimit   = 5000;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned DrainCycles  = 6;
  localparam int unsigned PressurePhase = 3;
  localparam logic [1:0]  KindUnused   = 2'd3;
  localparam logic [CrcW-1:0] CheckCrc = 32'hCBF4_3926;

  typedef struct packed {
    logic             new_slot;
    logic [AddrW-1:0] boot_address;
    logic             crc_match;
    logic [CrcW-1:0]  computed_crc;
    logic             status_rewrite;
    logic             jump_ok;
  } boot_result_t;

  typedef struct packed {
    logic [31:0]       magic;
    logic              slot;
    logic [1:0]        upgrade;
    logic [CrcW-1:0]   expected;
    logic [CountW-1:0] size;
  } status_rec_t;

  typedef struct packed {
    logic [1:0]   kind;
    logic [7:0]   data;
    logic [31:0]  sp;
    logic [31:0]  rv;
    bit           typed;
    boot_result_t want;
    bit           reload;
    status_rec_t  status;
  } stim_row_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [1:0]           kind_i;
  logic [7:0]           data_byte_i;
  logic [31:0]          stack_pointer_i;
  logic [31:0]          reset_vector_i;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 new_slot_o;
  logic [AddrW-1:0]     boot_address_o;
  logic                 crc_match_o;
  logic [CrcW-1:0]      computed_crc_o;
  logic                 status_rewrite_o;
  logic                 jump_ok_o;

  logic [31:0]       sel_magic;
  logic              sel_slot;
  logic [1:0]        sel_upgrade;
  logic [CrcW-1:0]   sel_expected;
  logic [CountW-1:0] sel_size;
  logic [CrcW-1:0]   image_crc;
  logic [CountW-1:0] image_bytes;

  boot_result_t pending_results[$];

  int unsigned mismatches = 0;
  int unsigned accepted_items = 0;
  int unsigned counted_items = 0;
  int unsigned results_checked = 0;
  int unsigned slot_switches = 0;
  int unsigned magic_recoveries = 0;
  int unsigned phases = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned mode_left = 0;
  stall_mode_e stall_mode = STALL_NONE;

  ab_boot_image_verify_select dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .kind_i           (kind_i),
    .data_byte_i      (data_byte_i),
    .stack_pointer_i  (stack_pointer_i),
    .reset_vector_i   (reset_vector_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .new_slot_o       (new_slot_o),
    .boot_address_o   (boot_address_o),
    .crc_match_o      (crc_match_o),
    .computed_crc_o   (computed_crc_o),
    .status_rewrite_o (status_rewrite_o),
    .jump_ok_o        (jump_ok_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [CrcW-1:0] crc_feed(logic [CrcW-1:0] acc, logic [7:0] b);
    logic [CrcW-1:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      r = (r[0] ^ b[i]) ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    end
    return r;
  endfunction

  function automatic boot_result_t outcome(logic slot, logic [AddrW-1:0] addr, logic match,
                                           logic [CrcW-1:0] crc, logic rewrite, logic ok);
    boot_result_t r;
    r.new_slot       = slot;
    r.boot_address   = addr;
    r.crc_match      = match;
    r.computed_crc   = crc;
    r.status_rewrite = rewrite;
    r.jump_ok        = ok;
    return r;
  endfunction

  function automatic stim_row_t stim_row(logic [1:0] kind, logic [7:0] data, logic [31:0] sp,
                                         logic [31:0] rv, bit typed = 1'b0,
                                         boot_result_t want = '0, bit reload = 1'b0,
                                         status_rec_t status = '0);
    stim_row_t r;
    r.kind   = kind;
    r.data   = data;
    r.sp     = sp;
    r.rv     = rv;
    r.typed  = typed;
    r.want   = want;
    r.reload = reload;
    r.status = status;
    return r;
  endfunction

  function automatic logic [31:0] pick_stack_pointer();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return SramLo - 32'd8 + $urandom_range(0, 16);
      2: return SramHi - 32'd8 + $urandom_range(0, 16);
      default: return SramLo + $urandom_range(0, 32'h4FFF);
    endcase
  endfunction

  function automatic logic [31:0] pick_reset_vector();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return FlashBase - 32'd4 + $urandom_range(0, 8);
      2: return FlashBase + $urandom_range(0, 32'h000F_FFFF);
      default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
    endcase
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endfunction

  task automatic predict_selection(input logic [1:0] kind, input logic [7:0] data,
                                   input logic [31:0] sp, input logic [31:0] rv,
                                   output bit makes_result, output bit counts,
                                   output boot_result_t res);
    logic [CountW-1:0] limit;
    logic [CrcW-1:0]   final_crc;
    logic              match;
    logic              rewrite;
    makes_result = 1'b0;
    counts = 1'b1;
    res = '0;
    case (kind)
      KIND_BYTE: begin
        limit = (sel_size > MaxImageBytes) ? CountW'(MaxImageBytes) : sel_size;
        if (image_bytes < limit) begin
          image_crc = crc_feed(image_crc, data);
          image_bytes++;
        end else begin
          counts = 1'b0;
        end
      end
      KIND_FINISH: begin
        final_crc = ~image_crc;
        match = (final_crc == sel_expected);
        rewrite = 1'b0;
        if (sel_magic != GoodMagic) begin
          sel_magic = GoodMagic;
          sel_slot = 1'b0;
          sel_upgrade = '0;
          sel_expected = '0;
          sel_size = '0;
          rewrite = 1'b1;
          magic_recoveries++;
        end else if (sel_upgrade == UpgradePending) begin
          if (match) begin
            sel_slot = ~sel_slot;
            slot_switches++;
          end
          sel_upgrade = '0;
          rewrite = 1'b1;
        end
        res = outcome(sel_slot, sel_slot ? SlotBBase : SlotABase, match, final_crc, rewrite,
                      1'b0);
        makes_result = 1'b1;
        image_crc = CrcInit;
        image_bytes = '0;
      end
      KIND_VECTOR: begin
        res = outcome(sel_slot, sel_slot ? SlotBBase : SlotABase, 1'b0, '0, 1'b0,
                      (sp >= SramLo) && (sp < SramHi) && (rv >= FlashBase));
        makes_result = 1'b1;
      end
      default: counts = 1'b0;
    endcase
  endtask

  task automatic send_item(input logic [1:0] kind, input logic [7:0] data,
                           input logic [31:0] sp, input logic [31:0] rv,
                           input bit typed = 1'b0, input boot_result_t want = '0);
    bit           makes_result;
    bit           counts;
    boot_result_t res;
    int unsigned  gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 40);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i      <= 1'b1;
    kind_i          <= kind;
    data_byte_i     <= data;
    stack_pointer_i <= sp;
    reset_vector_i  <= rv;
    do @(posedge clk_i); while (in_stall_o);
    predict_selection(kind, data, sp, rv, makes_result, counts, res);
    if (makes_result) pending_results.push_back(typed ? want : res);
    if (counts) counted_items++;
    accepted_items++;
  endtask

  task automatic cfg_write(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] word);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= word;
    @(posedge clk_i);
    case (idx)
      CFG_STATUS_MAGIC:  sel_magic = word;
      CFG_ACTIVE_SLOT:   sel_slot = word[0];
      CFG_UPGRADE_STATE: sel_upgrade = word[1:0];
      CFG_EXPECTED_CRC:  sel_expected = word;
      CFG_IMAGE_SIZE:    sel_size = word[CountW-1:0];
      default: ;
    endcase
  endtask

  // Narrow registers are written with random upper bits, which the block must drop.
  task automatic apply_status(input status_rec_t s);
    logic [CfgDataW-1:0] word;
    cfg_write(CFG_STATUS_MAGIC, s.magic);
    word = $urandom;
    word[0] = s.slot;
    cfg_write(CFG_ACTIVE_SLOT, word);
    word = $urandom;
    word[1:0] = s.upgrade;
    cfg_write(CFG_UPGRADE_STATE, word);
    cfg_write(CFG_EXPECTED_CRC, s.expected);
    word = $urandom;
    word[CountW-1:0] = s.size;
    cfg_write(CFG_IMAGE_SIZE, word);
    cfg_write(CfgIndexW'(CFG_IMAGE_SIZE + $urandom_range(1, 3)), $urandom);
    cfg_we_i <= 1'b0;
  endtask

  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = HoldCycles;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 160);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE:  out_stall_i <= 1'b0;
        STALL_LIGHT: out_stall_i <= ($urandom_range(0, 99) < 30);
        STALL_HEAVY: out_stall_i <= ($urandom_range(0, 99) < 70);
        default:     out_stall_i <= (mode_left % 3 == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin : result_check
    boot_result_t got;
    boot_result_t want;
    if (rst_ni && ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = outcome(new_slot_o, boot_address_o, crc_match_o, computed_crc_o,
                    status_rewrite_o, jump_ok_o);
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got %h", $time, got);
      end else begin
        want = pending_results.pop_front();
        check_field("new_slot", 64'(want.new_slot), 64'(got.new_slot));
        check_field("boot_address", 64'(want.boot_address), 64'(got.boot_address));
        check_field("crc_match", 64'(want.crc_match), 64'(got.crc_match));
        check_field("computed_crc", 64'(want.computed_crc), 64'(got.computed_crc));
        check_field("status_rewrite", 64'(want.status_rewrite), 64'(got.status_rewrite));
        check_field("jump_ok", 64'(want.jump_ok), 64'(got.jump_ok));
        results_checked++;
      end
    end
  end

  initial begin
    while (idle_cycles < StuckLimit) @(posedge clk_i);
    $display("Timeout: no transaction for %0d cycles", StuckLimit);
    $display("ab_boot_image_verify_select_tb: FAIL");
    $finish;
  end

  initial begin
    stim_row_t        directed[$];
    status_rec_t      st;
    logic [7:0]       image[$];
    logic [7:0]       b;
    logic [CrcW-1:0]  crc;
    int unsigned      pick;
    int unsigned      size;
    int unsigned      nbytes;
    int unsigned      extra;

    cfg_we_i        = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    kind_i          = '0;
    data_byte_i     = '0;
    stack_pointer_i = '0;
    reset_vector_i  = '0;
    sel_magic       = '0;
    sel_slot        = 1'b0;
    sel_upgrade     = '0;
    sel_expected    = '0;
    sel_size        = '0;
    image_crc       = CrcInit;
    image_bytes     = '0;

    // Reset state: bad magic, slot A, image size zero.
    directed.push_back(stim_row(KIND_VECTOR, 8'h00, SramLo, FlashBase, 1'b1,
                                outcome(1'b0, SlotABase, 1'b0, '0, 1'b0, 1'b1)));
    directed.push_back(stim_row(KIND_VECTOR, 8'hFF, SramHi - 32'd1, 32'hFFFF_FFFF, 1'b1,
                                outcome(1'b0, SlotABase, 1'b0, '0, 1'b0, 1'b1)));
    directed.push_back(stim_row(KIND_VECTOR, 8'h00, SramHi, FlashBase, 1'b1,
                                outcome(1'b0, SlotABase, 1'b0, '0, 1'b0, 1'b0)));
    directed.push_back(stim_row(KIND_VECTOR, 8'h00, SramLo - 32'd1, FlashBase, 1'b1,
                                outcome(1'b0, SlotABase, 1'b0, '0, 1'b0, 1'b0)));
    directed.push_back(stim_row(KIND_VECTOR, 8'h00, SramLo + 32'h100, FlashBase - 32'd1, 1'b1,
                                outcome(1'b0, SlotABase, 1'b0, '0, 1'b0, 1'b0)));
    directed.push_back(stim_row(KIND_VECTOR, 8'hFF, 32'hFFFF_FFFF, 32'h0, 1'b1,
                                outcome(1'b0, SlotABase, 1'b0, '0, 1'b0, 1'b0)));
    directed.push_back(stim_row(KIND_BYTE, 8'h00, 32'h0, 32'h0));
    directed.push_back(stim_row(KIND_BYTE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    directed.push_back(stim_row(KindUnused, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    directed.push_back(stim_row(KIND_FINISH, 8'h00, 32'h0, 32'h0, 1'b1,
                                outcome(1'b0, SlotABase, 1'b1, '0, 1'b1, 1'b0)));
    directed.push_back(stim_row(KIND_FINISH, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                                outcome(1'b0, SlotABase, 1'b1, '0, 1'b0, 1'b0)));
    // The ASCII digits one to nine give the well-known CRC-32 check value.
    st = '{magic: GoodMagic, slot: 1'b0, upgrade: UpgradePending, expected: CheckCrc,
           size: CountW'(9)};
    for (int c = 8'h31; c <= 8'h39; c++) begin
      directed.push_back(stim_row(KIND_BYTE, 8'(c), $urandom, $urandom, 1'b0, '0,
                                  c == 8'h31, st));
    end
    directed.push_back(stim_row(KIND_BYTE, 8'h00, 32'h0, 32'h0));
    directed.push_back(stim_row(KIND_FINISH, 8'h00, 32'h0, 32'h0, 1'b1,
                                outcome(1'b1, SlotBBase, 1'b1, CheckCrc, 1'b1, 1'b0)));
    directed.push_back(stim_row(KIND_VECTOR, 8'h00, SramLo + 32'd4, FlashBase + 32'h9000,
                                1'b1, outcome(1'b1, SlotBBase, 1'b0, '0, 1'b0, 1'b1)));
    directed.push_back(stim_row(KIND_BYTE, 8'hA5, 32'h0, 32'h0));
    directed.push_back(stim_row(KIND_FINISH, 8'h00, 32'h0, 32'h0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].reload) begin
        quiesce();
        apply_status(directed[i].status);
      end
      send_item(directed[i].kind, directed[i].data, directed[i].sp, directed[i].rv,
                directed[i].typed, directed[i].want);
    end

    while (counted_items < ItemTarget) begin
      quiesce();
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        size = 0;
      end else if (pick < 80) begin
        size = $urandom_range(1, 48);
      end else if (pick < 93) begin
        size = $urandom_range(49, 400);
      end else begin
        case ($urandom_range(0, 2))
          0: size = MaxImageBytes;
          1: size = (1 << CountW) - 1;
          default: size = $urandom_range(MaxImageBytes + 1, (1 << CountW) - 1);
        endcase
      end
      if (size > 400) begin
        nbytes = $urandom_range(1, 60);
      end else begin
        case ($urandom_range(0, 9))
          0, 1: nbytes = size + $urandom_range(1, 4);
          2: nbytes = $urandom_range(0, size);
          default: nbytes = size;
        endcase
      end
      image.delete();
      crc = CrcInit;
      for (int i = 0; i < nbytes; i++) begin
        b = 8'($urandom);
        image.push_back(b);
        if (i < size && i < MaxImageBytes) crc = crc_feed(crc, b);
      end
      case ($urandom_range(0, 9))
        0: st.magic = '0;
        1: st.magic = 32'hFFFF_FFFF;
        2: st.magic = GoodMagic ^ (32'd1 << $urandom_range(0, 31));
        3: st.magic = $urandom;
        default: st.magic = GoodMagic;
      endcase
      st.slot = 1'($urandom_range(0, 1));
      st.upgrade = ($urandom_range(0, 99) < 55) ? UpgradePending : 2'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      if (pick < 60) st.expected = ~crc;
      else if (pick < 70) st.expected = '0;
      else if (pick < 80) st.expected = '1;
      else st.expected = $urandom;
      st.size = CountW'(size);
      apply_status(st);

      if (phases == PressurePhase) begin
        hold_requests++;
        repeat (40) send_item(KIND_VECTOR, 8'($urandom), pick_stack_pointer(),
                              pick_reset_vector());
      end
      foreach (image[i]) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          send_item(KIND_VECTOR, 8'($urandom), pick_stack_pointer(), pick_reset_vector());
        end else if (pick < 11) begin
          send_item(KindUnused, 8'($urandom), $urandom, $urandom);
        end
        send_item(KIND_BYTE, image[i], $urandom, $urandom);
      end
      send_item(KIND_FINISH, 8'($urandom), $urandom, $urandom);
      if ($urandom_range(0, 3) == 0) begin
        extra = $urandom_range(0, 5);
        repeat (extra) send_item(KIND_BYTE, 8'($urandom), $urandom, $urandom);
        send_item(KIND_VECTOR, 8'($urandom), pick_stack_pointer(), pick_reset_vector());
        send_item(KIND_FINISH, 8'($urandom), $urandom, $urandom);
      end
      phases++;
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Summary: %0d transactions accepted, %0d effective, %0d results checked",
             accepted_items, counted_items, results_checked);
    $display("Summary: %0d status settings, %0d slot switches, %0d bad-magic recoveries",
             phases, slot_switches, magic_recoveries);
    if (mismatches == 0) begin
      $display("ab_boot_image_verify_select_tb: PASS");
    end else begin
      $display("ab_boot_image_verify_select_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/abvs_pkg.sv
src/abvs_crc.sv
src/abvs_status.sv
src/ab_boot_image_verify_select.sv
tb/sv/ab_boot_image_verify_select_tb.sv
